>>> rtl/mtc_pkg.sv
// Shared constants, codes and types for the mismatch threshold clustering block.
package mtc_pkg;

    localparam int MAX_SEQS = 256;
    localparam int MAX_COLS = 512;
    localparam int SEQ_W    = $clog2(MAX_SEQS);
    localparam int CNT_W    = SEQ_W + 1;
    localparam int COL_W    = $clog2(MAX_COLS) + 1;
    localparam int ADDR_W   = $clog2(MAX_SEQS * MAX_COLS);
    localparam int FRAC_W   = 18;
    localparam int FRAC_MAX = 131072;
    localparam int PROD_W   = COL_W + FRAC_W;
    localparam int LIM_W    = PROD_W - 16;

    localparam logic [7:0] GAP_BYTE = 8'd45;

    localparam logic KIND_RUN  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_RUN  = 2'd1,
        ACT_READ = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        REG_SEQ_COUNT = 2'd0,
        REG_COL_COUNT = 2'd1,
        REG_FRACTION  = 2'd2,
        REG_CLUST_OFF = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic             clear;
        logic             we;
        logic [SEQ_W-1:0] wr_addr;
        logic [SEQ_W-1:0] wr_data;
    } lbl_ctl_t;

endpackage

>>> rtl/mtc_store.sv
// Residue memory: one write port, two registered read ports.
module mtc_store (
    input  logic                      clk,
    input  logic                      we,
    input  logic [mtc_pkg::ADDR_W-1:0] wr_addr,
    input  logic [7:0]                wr_data,
    input  logic [mtc_pkg::ADDR_W-1:0] rd_addr_a,
    input  logic [mtc_pkg::ADDR_W-1:0] rd_addr_b,
    output logic [7:0]                rd_data_a,
    output logic [7:0]                rd_data_b
);
    import mtc_pkg::*;

    logic [7:0] mem [MAX_SEQS*MAX_COLS];
    logic [7:0] rd_a_reg;
    logic [7:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

>>> rtl/mtc_label.sv
// Cluster label table: memory with valid bits, unset entries read as their own index.
module mtc_label (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mtc_pkg::lbl_ctl_t        ctl,
    input  logic [mtc_pkg::SEQ_W-1:0] rd_addr_a,
    input  logic [mtc_pkg::SEQ_W-1:0] rd_addr_b,
    output logic [mtc_pkg::SEQ_W-1:0] rd_data_a,
    output logic [mtc_pkg::SEQ_W-1:0] rd_data_b
);
    import mtc_pkg::*;

    logic [SEQ_W-1:0]    mem [MAX_SEQS];
    logic [MAX_SEQS-1:0] valid_reg;
    logic [SEQ_W-1:0]    rd_a_reg;
    logic [SEQ_W-1:0]    rd_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.clear)
        begin
            valid_reg <= '0;
        end
        else if (ctl.we)
        begin
            valid_reg[ctl.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
        rd_a_reg <= valid_reg[rd_addr_a] ? mem[rd_addr_a] : rd_addr_a;
        rd_b_reg <= valid_reg[rd_addr_b] ? mem[rd_addr_b] : rd_addr_b;
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

>>> rtl/mismatch_threshold_clustering.sv
// Top level: request port, config registers and the clustering sequencer.
// Load: one request per cycle while idle; label read: the label is registered from the
// request index and placed in the result by S_READ_OUT. Run: lengths per sequence, then
// per pair a label check, a mismatch count when labels differ, a relabel when it merges;
// all column reads share one two-port residue memory. No request is taken while a result waits.
// Reset clears control, config to defaults, labels to own index; residues stay unset.
module mismatch_threshold_clustering (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [17:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // residue[7:0], sequence_index[15:8]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // cluster_label[7:0], cluster_total[16:8], zero
    output logic        m_axis_tuser    // kind[0]
);
    import mtc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_READ_OUT, S_LEN_RD, S_LEN_ACC, S_PAIR_RD, S_PAIR_CHK, S_LIMIT,
        S_MIS_RD, S_MIS_ACC, S_DECIDE, S_REL_RD, S_REL_WR, S_NEXT, S_DONE
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     seq_count_reg;
    logic [COL_W-1:0]     col_count_reg;
    logic [FRAC_W-1:0]    frac_reg;
    logic                 off_reg;
    logic [ADDR_W-1:0]    ptr_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [COL_W-1:0]     cols_reg;
    logic [FRAC_W-1:0]    fr_reg;
    logic [CNT_W-1:0]     i_reg;
    logic [SEQ_W-1:0]     j_reg;
    logic [CNT_W-1:0]     k_reg;
    logic [COL_W-1:0]     c_reg;
    logic [ADDR_W-1:0]    base_i_reg;
    logic [ADDR_W-1:0]    base_j_reg;
    logic [COL_W-1:0]     acc_reg;
    logic [COL_W-1:0]     minlen_reg;
    logic [LIM_W-1:0]     limit_reg;
    logic [SEQ_W-1:0]     lo_reg;
    logic [SEQ_W-1:0]     hi_reg;
    logic [CNT_W-1:0]     merges_reg;
    logic                 out_valid_reg;
    logic                 out_kind_reg;
    logic [SEQ_W-1:0]     out_label_reg;
    logic [CNT_W-1:0]     out_total_reg;

    logic [COL_W-1:0]     len_mem [MAX_SEQS];
    logic [COL_W-1:0]     len_i_reg;
    logic [COL_W-1:0]     len_j_reg;

    logic                 accept;
    action_t              action;
    logic                 store_we;
    logic [ADDR_W-1:0]    store_addr_a;
    logic [ADDR_W-1:0]    store_addr_b;
    logic [7:0]           store_a;
    logic [7:0]           store_b;
    lbl_ctl_t             lbl_ctl;
    logic [SEQ_W-1:0]     lbl_addr_a;
    logic [SEQ_W-1:0]     lbl_addr_b;
    logic [SEQ_W-1:0]     lbl_a;
    logic [SEQ_W-1:0]     lbl_b;
    logic [PROD_W-1:0]    product;
    logic                 len_we;

    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign action        = action_t'(s_axis_tuser);
    assign store_we      = accept && (action == ACT_LOAD);
    assign product       = minlen_reg * fr_reg;
    assign len_we        = (state_reg == S_LEN_RD) && (c_reg == cols_reg);

    always_comb
    begin
        store_addr_a    = base_i_reg + ADDR_W'(c_reg);
        store_addr_b    = base_j_reg + ADDR_W'(c_reg);
        lbl_addr_a      = s_axis_tdata[15:8];
        lbl_addr_b      = j_reg;
        lbl_ctl.clear   = accept && (action == ACT_RUN);
        lbl_ctl.we      = 1'b0;
        lbl_ctl.wr_addr = k_reg[SEQ_W-1:0];
        lbl_ctl.wr_data = lo_reg;
        unique case (state_reg)
            S_PAIR_RD: lbl_addr_a = i_reg[SEQ_W-1:0];
            S_REL_RD:  lbl_addr_a = k_reg[SEQ_W-1:0];
            S_REL_WR:  lbl_ctl.we = (lbl_a == hi_reg);
            default:   ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[i_reg[SEQ_W-1:0]] <= acc_reg;
        end
        len_i_reg <= len_mem[i_reg[SEQ_W-1:0]];
        len_j_reg <= len_mem[j_reg];
    end

    mtc_store u_store (
        .clk       (clk),
        .we        (store_we),
        .wr_addr   (ptr_reg),
        .wr_data   (s_axis_tdata[7:0]),
        .rd_addr_a (store_addr_a),
        .rd_addr_b (store_addr_b),
        .rd_data_a (store_a),
        .rd_data_b (store_b)
    );

    mtc_label u_label (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (lbl_ctl),
        .rd_addr_a (lbl_addr_a),
        .rd_addr_b (lbl_addr_b),
        .rd_data_a (lbl_a),
        .rd_data_b (lbl_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seq_count_reg <= CNT_W'(1);
            col_count_reg <= COL_W'(1);
            frac_reg      <= FRAC_W'(13107);
            off_reg       <= 1'b0;
            ptr_reg       <= '0;
            n_reg         <= '0;
            cols_reg      <= '0;
            fr_reg        <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            c_reg         <= '0;
            base_i_reg    <= '0;
            base_j_reg    <= '0;
            acc_reg       <= '0;
            minlen_reg    <= '0;
            limit_reg     <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            merges_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_RUN;
            out_label_reg <= '0;
            out_total_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (reg_index_t'(cfg_index))
                    REG_SEQ_COUNT: seq_count_reg <= cfg_data[CNT_W-1:0];
                    REG_COL_COUNT: col_count_reg <= cfg_data[COL_W-1:0];
                    REG_FRACTION:  frac_reg      <= cfg_data[FRAC_W-1:0];
                    REG_CLUST_OFF: off_reg       <= cfg_data[0];
                    default:       ;
                endcase
            end
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (action)
                            ACT_LOAD:
                            begin
                                ptr_reg <= ptr_reg + ADDR_W'(1);
                            end
                            ACT_RUN:
                            begin
                                n_reg      <= (seq_count_reg > CNT_W'(MAX_SEQS))
                                              ? CNT_W'(MAX_SEQS) : seq_count_reg;
                                cols_reg   <= (col_count_reg > COL_W'(MAX_COLS))
                                              ? COL_W'(MAX_COLS) : col_count_reg;
                                fr_reg     <= (frac_reg > FRAC_W'(FRAC_MAX))
                                              ? FRAC_W'(FRAC_MAX) : frac_reg;
                                i_reg      <= '0;
                                j_reg      <= '0;
                                c_reg      <= '0;
                                acc_reg    <= '0;
                                base_i_reg <= '0;
                                merges_reg <= '0;
                                state_reg  <= (seq_count_reg == '0) ? S_DONE : S_LEN_RD;
                            end
                            ACT_READ:
                            begin
                                state_reg <= S_READ_OUT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    out_kind_reg  <= KIND_READ;
                    out_label_reg <= lbl_a;
                    out_total_reg <= '0;
                    state_reg     <= S_IDLE;
                end
                S_LEN_RD:
                begin
                    if (c_reg == cols_reg)
                    begin
                        c_reg      <= '0;
                        acc_reg    <= '0;
                        base_i_reg <= base_i_reg + ADDR_W'(cols_reg);
                        i_reg      <= i_reg + CNT_W'(1);
                        if (i_reg + CNT_W'(1) == n_reg)
                        begin
                            if (off_reg || n_reg < CNT_W'(2))
                            begin
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                i_reg      <= CNT_W'(1);
                                j_reg      <= '0;
                                base_i_reg <= ADDR_W'(cols_reg);
                                base_j_reg <= '0;
                                state_reg  <= S_PAIR_RD;
                            end
                        end
                    end
                    else
                    begin
                        c_reg     <= c_reg + COL_W'(1);
                        state_reg <= S_LEN_ACC;
                    end
                end
                S_LEN_ACC:
                begin
                    if (store_a != GAP_BYTE)
                    begin
                        acc_reg <= acc_reg + COL_W'(1);
                    end
                    state_reg <= S_LEN_RD;
                end
                S_PAIR_RD:
                begin
                    state_reg <= S_PAIR_CHK;
                end
                S_PAIR_CHK:
                begin
                    lo_reg     <= (lbl_a < lbl_b) ? lbl_a : lbl_b;
                    hi_reg     <= (lbl_a < lbl_b) ? lbl_b : lbl_a;
                    minlen_reg <= (len_i_reg < len_j_reg) ? len_i_reg : len_j_reg;
                    state_reg  <= (lbl_a == lbl_b) ? S_NEXT : S_LIMIT;
                end
                S_LIMIT:
                begin
                    limit_reg <= product[PROD_W-1:16];
                    c_reg     <= '0;
                    acc_reg   <= '0;
                    state_reg <= S_MIS_RD;
                end
                S_MIS_RD:
                begin
                    if (c_reg == cols_reg)
                    begin
                        state_reg <= S_DECIDE;
                    end
                    else
                    begin
                        c_reg     <= c_reg + COL_W'(1);
                        state_reg <= S_MIS_ACC;
                    end
                end
                S_MIS_ACC:
                begin
                    if (store_a != store_b && store_a != GAP_BYTE && store_b != GAP_BYTE)
                    begin
                        acc_reg <= acc_reg + COL_W'(1);
                    end
                    state_reg <= S_MIS_RD;
                end
                S_DECIDE:
                begin
                    if (acc_reg == '0 || LIM_W'(acc_reg) < limit_reg)
                    begin
                        merges_reg <= merges_reg + CNT_W'(1);
                        k_reg      <= '0;
                        state_reg  <= S_REL_RD;
                    end
                    else
                    begin
                        state_reg <= S_NEXT;
                    end
                end
                S_REL_RD:
                begin
                    state_reg <= (k_reg == n_reg) ? S_NEXT : S_REL_WR;
                end
                S_REL_WR:
                begin
                    k_reg     <= k_reg + CNT_W'(1);
                    state_reg <= S_REL_RD;
                end
                S_NEXT:
                begin
                    if (CNT_W'(j_reg) + CNT_W'(1) == i_reg)
                    begin
                        if (i_reg + CNT_W'(1) == n_reg)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            i_reg      <= i_reg + CNT_W'(1);
                            j_reg      <= '0;
                            base_i_reg <= base_i_reg + ADDR_W'(cols_reg);
                            base_j_reg <= '0;
                            state_reg  <= S_PAIR_RD;
                        end
                    end
                    else
                    begin
                        j_reg      <= j_reg + SEQ_W'(1);
                        base_j_reg <= base_j_reg + ADDR_W'(cols_reg);
                        state_reg  <= S_PAIR_RD;
                    end
                end
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    out_kind_reg  <= KIND_RUN;
                    out_label_reg <= '0;
                    out_total_reg <= n_reg - merges_reg;
                    ptr_reg       <= '0;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {7'd0, out_total_reg, out_label_reg};

    a_merges_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (merges_reg < n_reg || n_reg == '0))
        else $error("merge count reached sequence count");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PAIR_RD) |-> (CNT_W'(j_reg) < i_reg && i_reg < n_reg))
        else $error("pair indices out of order");

    a_run_clears_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> (ptr_reg == '0 && out_valid_reg))
        else $error("run end left load pointer set");

    a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !s_axis_tready)
        else $error("request taken while result pending");

endmodule

>>> verif/tb_mismatch_threshold_clustering.sv
// Testbench for mismatch_threshold_clustering: directed and random requests checked against a predictor.
module tb_mismatch_threshold_clustering;
    import mtc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = MAX_SEQS * MAX_COLS;
    localparam int IDLE_LIMIT = 3000000;
    localparam int RANDOM_ITEMS = 150;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic       kind;
        logic [7:0] label;
        logic [8:0] total;
    } cluster_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [17:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;

    logic [7:0]  residue_mem [0:STORE_DEPTH-1];
    int          load_ptr;
    int          seq_len [0:MAX_SEQS-1];
    int          labels [0:MAX_SEQS-1];
    int          members [0:MAX_SEQS-1];
    int          seq_cfg;
    int          col_cfg;
    int          frac_cfg;
    int          off_cfg;

    cluster_result_t expected_q[$];
    int  err_count;
    int  sent_count;
    int  idle_cycles;
    bit  gaps_on;
    bit  stalls_on;
    logic [7:0] base_seq [0:MAX_COLS-1];

    mismatch_threshold_clustering DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int cluster_all();
        int n;
        int cols;
        int frac;
        int total;
        int minlen;
        int lim;
        int mm;
        int lo;
        int hi;
        logic [7:0] x;
        logic [7:0] y;
        n = seq_cfg > MAX_SEQS ? MAX_SEQS : seq_cfg;
        cols = col_cfg > MAX_COLS ? MAX_COLS : col_cfg;
        frac = frac_cfg > FRAC_MAX ? FRAC_MAX : frac_cfg;
        total = 0;
        for (int i = 0; i < MAX_SEQS; i++)
        begin
            labels[i] = i;
            members[i] = 1;
        end
        for (int i = 0; i < n; i++)
        begin
            seq_len[i] = 0;
            for (int c = 0; c < cols; c++)
                if (residue_mem[i * cols + c] != GAP_BYTE)
                    seq_len[i]++;
        end
        if (off_cfg == 0)
        begin
            for (int i = 0; i < n; i++)
            begin
                for (int j = 0; j < i; j++)
                begin
                    if (labels[j] == labels[i])
                        continue;
                    minlen = seq_len[i] < seq_len[j] ? seq_len[i] : seq_len[j];
                    lim = int'((longint'(minlen) * frac) >>> 16);
                    mm = 0;
                    for (int c = 0; c < cols; c++)
                    begin
                        x = residue_mem[i * cols + c];
                        y = residue_mem[j * cols + c];
                        if (x != y && x != GAP_BYTE && y != GAP_BYTE)
                            mm++;
                    end
                    if (!(mm == 0 || mm < lim))
                        continue;
                    lo = labels[j];
                    hi = labels[i];
                    if (lo > hi)
                    begin
                        lo = labels[i];
                        hi = labels[j];
                    end
                    for (int k = 0; k < n; k++)
                        if (labels[k] == hi)
                            labels[k] = lo;
                    members[lo] += members[hi];
                    members[hi] = 0;
                end
            end
        end
        for (int i = 0; i < n; i++)
            if (members[i] > 0)
                total++;
        load_ptr = 0;
        return total;
    endfunction

    function automatic void apply_request(logic [1:0] act, logic [7:0] res, logic [7:0] idx);
        cluster_result_t r;
        case (act)
            ACT_LOAD:
            begin
                residue_mem[load_ptr] = res;
                load_ptr = (load_ptr + 1) % STORE_DEPTH;
            end
            ACT_RUN:
            begin
                r.kind = KIND_RUN;
                r.label = 8'd0;
                r.total = 9'(cluster_all());
                expected_q.push_back(r);
            end
            ACT_READ:
            begin
                r.kind = KIND_READ;
                r.label = 8'(labels[idx]);
                r.total = 9'd0;
                expected_q.push_back(r);
            end
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_request(logic [1:0] act, logic [7:0] res, logic [7:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {idx, res};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        apply_request(act, res, idx);
        sent_count++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [17:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SEQ_COUNT: seq_cfg = int'(value[8:0]);
            REG_COL_COUNT: col_cfg = int'(value[9:0]);
            REG_FRACTION:  frac_cfg = int'(value);
            REG_CLUST_OFF: off_cfg = int'(value[0]);
            default: ;
        endcase
    endtask

    task automatic configure(int n, int cols, int frac, int off);
        write_reg(REG_SEQ_COUNT, 18'(n));
        write_reg(REG_COL_COUNT, 18'(cols));
        write_reg(REG_FRACTION, 18'(frac));
        write_reg(REG_CLUST_OFF, 18'(off));
    endtask

    function automatic logic [7:0] mutate(logic [7:0] base, int rate);
        int r;
        r = $urandom_range(0, 99);
        if (r < rate / 3)
            return GAP_BYTE;
        if (r < rate)
            return 8'($urandom_range(0, 255));
        return base;
    endfunction

    // load a full alignment of effective size, then run and read labels
    task automatic load_run_read(int rate, int reads);
        int n;
        int cols;
        n = seq_cfg > MAX_SEQS ? MAX_SEQS : seq_cfg;
        cols = col_cfg > MAX_COLS ? MAX_COLS : col_cfg;
        for (int c = 0; c < cols; c++)
            base_seq[c] = $urandom_range(0, 3) == 0 ? GAP_BYTE : 8'($urandom_range(0, 255));
        for (int s = 0; s < n; s++)
        begin
            for (int c = 0; c < cols; c++)
            begin
                if ($urandom_range(0, 39) == 0)
                    send_request(ACT_READ, 8'($urandom), 8'($urandom));
                if ($urandom_range(0, 49) == 0)
                    send_request(ACT_UNUSED, 8'($urandom), 8'($urandom));
                send_request(ACT_LOAD, mutate(base_seq[c], rate), 8'($urandom));
            end
        end
        send_request(ACT_RUN, 8'($urandom), 8'($urandom));
        for (int k = 0; k < reads; k++)
            send_request(ACT_READ, 8'($urandom), 8'(k < n ? k : $urandom_range(0, 255)));
        drain();
    endtask

    task automatic test_defaults();
        send_request(ACT_READ, 8'hFF, 8'd255);
        send_request(ACT_READ, 8'h00, 8'd0);
        send_request(ACT_LOAD, GAP_BYTE, 8'd0);
        send_request(ACT_RUN, 8'h00, 8'h00);
        send_request(ACT_READ, 8'h00, 8'd0);
        drain();
    endtask

    task automatic test_directed();
        logic [7:0] rows [0:3][0:3];
        rows = '{'{8'h41, 8'h43, 8'h47, 8'h54},
                 '{8'h41, 8'h43, GAP_BYTE, 8'h54},
                 '{8'h00, 8'hFF, 8'h00, 8'hFF},
                 '{GAP_BYTE, GAP_BYTE, GAP_BYTE, GAP_BYTE}};
        configure(4, 4, 65536, 0);
        for (int s = 0; s < 4; s++)
            for (int c = 0; c < 4; c++)
                send_request(ACT_LOAD, rows[s][c], 8'hAA);
        send_request(ACT_UNUSED, 8'hFF, 8'hFF);
        send_request(ACT_RUN, 8'h55, 8'h55);
        for (int k = 0; k < 4; k++)
            send_request(ACT_READ, 8'h00, 8'(k));
        send_request(ACT_READ, 8'hFF, 8'd255);
        drain();
    endtask

    task automatic test_register_extremes();
        configure(0, 1, 0, 0);
        send_request(ACT_RUN, 8'h00, 8'h00);
        drain();
        configure(511, 1, 262143, 1);
        load_run_read(50, 4);
        configure(1, 1023, 131072, 0);
        load_run_read(30, 2);
        configure(2, 40, 262143, 0);
        load_run_read(5, 3);
        configure(6, 0, 131072, 0);
        send_request(ACT_RUN, 8'h00, 8'h00);
        send_request(ACT_READ, 8'h00, 8'd5);
        drain();
        configure(6, 5, 0, 0);
        load_run_read(20, 6);
    endtask

    task automatic test_full_alignment();
        configure(256, 1, 131072, 0);
        load_run_read(60, 8);
    endtask

    task automatic test_random();
        int r;
        int start;
        start = sent_count;
        while (sent_count - start < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            gaps_on = r % 5 != 0;
            stalls_on = r % 7 != 0;
            configure($urandom_range(2, 10), $urandom_range(1, 12),
                      r < 10 ? $urandom_range(131072, 262143) : $urandom_range(0, 131072),
                      r > 89 ? 1 : 0);
            load_run_read($urandom_range(0, 60), $urandom_range(2, 12));
        end
        gaps_on = 1'b1;
        stalls_on = 1'b1;
    endtask

    always @(posedge clk)
    begin : result_check
        cluster_result_t e;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result tdata=%h tuser=%b", m_axis_tdata, m_axis_tuser);
                err_count++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (m_axis_tuser !== e.kind)
                begin
                    $error("kind: expected %0d actual %0d", e.kind, m_axis_tuser);
                    err_count++;
                end
                if (m_axis_tdata[7:0] !== e.label)
                begin
                    $error("cluster_label: expected %0d actual %0d", e.label, m_axis_tdata[7:0]);
                    err_count++;
                end
                if (m_axis_tdata[16:8] !== e.total)
                begin
                    $error("cluster_total: expected %0d actual %0d", e.total, m_axis_tdata[16:8]);
                    err_count++;
                end
                if (m_axis_tdata[23:17] !== 7'd0)
                begin
                    $error("pad: expected 0 actual %0d", m_axis_tdata[23:17]);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : ready_drive
        int r;
        int stall_left;
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (!stalls_on || r < 60)
                m_axis_tready <= 1'b1;
            else
            begin
                stall_left = r < 95 ? $urandom_range(0, 2) : $urandom_range(8, 30);
                m_axis_tready <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_SEQ_COUNT;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = ACT_LOAD;
        m_axis_tready = 1'b0;
        err_count = 0;
        sent_count = 0;
        idle_cycles = 0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        load_ptr = 0;
        seq_cfg = 1;
        col_cfg = 1;
        frac_cfg = 13107;
        off_cfg = 0;
        for (int i = 0; i < MAX_SEQS; i++)
        begin
            labels[i] = i;
            members[i] = 1;
            seq_len[i] = 0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_directed();
        test_register_extremes();
        test_full_alignment();
        test_random();
        drain();
        repeat (20) @(posedge clk);
        if (err_count == 0 && expected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
